>>> rtl/psvg_pkg.sv
// Shared types and constants of the polygon and star vertex generator.
package psvg_pkg;

  localparam int unsigned LEN_W = 23;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned CW = 34;
  localparam int unsigned OFF_W = 28;
  localparam int unsigned SUM_W = 34;
  localparam int unsigned PROD_W = LEN_W + 1 + CW;
  localparam logic signed [CW-1:0] ONE_GAIN = CW'(652032874);

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef enum logic [1:0] {
    MODE_CIRCLE = 2'd0,
    MODE_STAR   = 2'd1,
    MODE_SQUARE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

endpackage

>>> rtl/psvg_if.sv
// Request and vertex channel interfaces.
interface psvg_req_if #(parameter int unsigned COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [22:0]                  primary_length;
  logic [22:0]                  inner_radius;
  logic [6:0]                   count;
  modport source (output valid, mode, center_x, center_y, primary_length, inner_radius,
                  count, input ready);
  modport sink (input valid, mode, center_x, center_y, primary_length, inner_radius,
                count, output ready);
endinterface

interface psvg_vtx_if #(parameter int unsigned COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [5:0]                   vertex_index;
  logic                         last;
  modport source (output valid, point_x, point_y, vertex_index, last, input ready);
  modport sink (input valid, point_x, point_y, vertex_index, last, output ready);
endinterface

>>> rtl/polygon_star_vertex_generator.sv
// Vertex generator top level: request sequencer, CORDIC pipeline, scaling and saturation.
//
//   channel  dir  transaction
//   req      in   one shape request (mode, center, lengths, count)
//   vtx      out  one vertex (point, index, last flag)
//
// Circle and star requests run a serial divider for the angle step, then issue one vertex
// per cycle while the output is not stalled; square requests skip the divider and issue four vertices.
// A request is accepted in ST_IDLE, runs the divider in ST_DIV if any, then issues n vertices in ST_RUN.
// Issued vertices pass the issue register, the CORDIC stages, the product register and the output register.
// The whole pipeline holds while the vertex output is valid and not taken.
// Reset is asynchronous, active low, and clears the sequencer and all valid bits.
module polygon_star_vertex_generator #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned ANGLE_BITS   = 16
) (
  input logic clk_i,
  input logic rst_ni,
  psvg_req_if.sink   req,
  psvg_vtx_if.source vtx
);
  import psvg_pkg::*;

  localparam int unsigned NS = CORDIC_STEPS;
  localparam int unsigned DC_W = $clog2(ANGLE_BITS + 2);

  typedef struct packed {
    logic                         valid;
    logic                         sq;
    logic [1:0]                   quad;
    logic signed [CW-1:0]         x;
    logic signed [CW-1:0]         y;
    logic signed [PHASE_W-1:0]    z;
    logic [LEN_W-1:0]             rad;
    logic signed [OFF_W-1:0]      off_x;
    logic signed [OFF_W-1:0]      off_y;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [IDX_W-1:0]             idx;
    logic                         last;
  } stage_t;

  state_e                       state_q;
  logic                         star_q, sq_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [LEN_W-1:0]             r1_q, r2_q;
  logic [CNT_W-1:0]             n_q, i_q;
  logic [7:0]                   rem_q;
  logic [ANGLE_BITS-1:0]        quo_q;
  logic [DC_W-1:0]              dcnt_q;
  logic [ANGLE_BITS-1:0]        acc_q;
  logic [7:0]                   racc_q;

  stage_t stg_q [NS+1];
  stage_t mul_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic                     out_valid_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q;
  logic [IDX_W-1:0]         oidx_q;
  logic                     olast_q;

  logic advance, accept, issue;
  logic [CNT_W-1:0] cnt_lo, n_new;
  logic [7:0] rem_sh, racc_sum;
  logic [ANGLE_BITS-1:0] angle;
  logic [PHASE_W-1:0] phase;
  logic [LEN_W-2:0] half;
  stage_t issue_d;

  assign advance = !out_valid_q || vtx.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign issue = (state_q == ST_RUN) && advance;

  always_comb begin
    cnt_lo = req.count;
    n_new = req.count;
    if (mode_e'(req.mode) == MODE_STAR) begin
      if (cnt_lo < CNT_W'(2)) cnt_lo = CNT_W'(2);
      if (cnt_lo > CNT_W'(MAX_VERTICES / 2)) cnt_lo = CNT_W'(MAX_VERTICES / 2);
      n_new = CNT_W'({cnt_lo, 1'b0});
    end else begin
      if (n_new < CNT_W'(3)) n_new = CNT_W'(3);
      if (n_new > CNT_W'(MAX_VERTICES)) n_new = CNT_W'(MAX_VERTICES);
    end
  end

  assign rem_sh = {rem_q[6:0], (dcnt_q == '0)};
  assign racc_sum = racc_q + rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0;
      n_q <= '0;
      rem_q <= '0;
      dcnt_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            i_q <= '0;
            rem_q <= '0;
            dcnt_q <= '0;
            if (mode_e'(req.mode) == MODE_SQUARE) begin
              n_q <= CNT_W'(4);
              state_q <= ST_RUN;
            end else if (mode_e'(req.mode) != MODE_NONE) begin
              n_q <= n_new;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= (rem_sh >= 8'(n_q)) ? rem_sh - 8'(n_q) : rem_sh;
          dcnt_q <= dcnt_q + DC_W'(1);
          if (dcnt_q == DC_W'(ANGLE_BITS)) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (advance) begin
            i_q <= i_q + CNT_W'(1);
            if (i_q == n_q - CNT_W'(1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      star_q <= (mode_e'(req.mode) == MODE_STAR);
      sq_q <= (mode_e'(req.mode) == MODE_SQUARE);
      cx_q <= req.center_x;
      cy_q <= req.center_y;
      r1_q <= req.primary_length;
      r2_q <= req.inner_radius;
      acc_q <= '0;
      racc_q <= '0;
    end
    if (state_q == ST_DIV) begin
      quo_q <= {quo_q[ANGLE_BITS-2:0], (rem_sh >= 8'(n_q))};
    end
    if (issue) begin
      if (racc_sum >= 8'(n_q)) begin
        racc_q <= racc_sum - 8'(n_q);
        acc_q <= acc_q + quo_q + ANGLE_BITS'(1);
      end else begin
        racc_q <= racc_sum;
        acc_q <= acc_q + quo_q;
      end
    end
  end

  assign half = r1_q[LEN_W-1:1];

  always_comb begin
    angle = star_q ? acc_q - ANGLE_BITS'(1 << (ANGLE_BITS - 2)) : acc_q;
    phase = {angle, {(PHASE_W - ANGLE_BITS){1'b0}}};
    issue_d.valid = issue;
    issue_d.sq = sq_q;
    issue_d.quad = phase[PHASE_W-1:PHASE_W-2];
    issue_d.x = ONE_GAIN;
    issue_d.y = '0;
    issue_d.z = $signed({2'b00, phase[PHASE_W-3:0]});
    issue_d.rad = (star_q && i_q[0]) ? r2_q : r1_q;
    issue_d.off_x = (i_q[1:0] == 2'd0 || i_q[1:0] == 2'd3) ?
                    -$signed(OFF_W'(half)) : $signed(OFF_W'(half));
    issue_d.off_y = (i_q[1] == 1'b0) ? -$signed(OFF_W'(half)) : $signed(OFF_W'(half));
    issue_d.cx = cx_q;
    issue_d.cy = cy_q;
    issue_d.idx = i_q[IDX_W-1:0];
    issue_d.last = (i_q == n_q - CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q[0] <= '0;
    end else if (advance) begin
      stg_q[0] <= issue_d;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    stage_t nxt;
    logic signed [CW-1:0] dx, dy;
    logic signed [PHASE_W-1:0] t;
    always_comb begin
      nxt = stg_q[k];
      dx = stg_q[k].y >>> k;
      dy = stg_q[k].x >>> k;
      t = $signed({2'b00, ATAN_TURNS[k]});
      if (!stg_q[k].z[PHASE_W-1]) begin
        nxt.x = stg_q[k].x - dx;
        nxt.y = stg_q[k].y + dy;
        nxt.z = stg_q[k].z - t;
      end else begin
        nxt.x = stg_q[k].x + dx;
        nxt.y = stg_q[k].y - dy;
        nxt.z = stg_q[k].z + t;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[k+1] <= '0;
      end else if (advance) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  logic signed [CW-1:0] trig_c, trig_s;
  always_comb begin
    case (stg_q[NS].quad)
      2'd0: begin trig_c = stg_q[NS].x; trig_s = stg_q[NS].y; end
      2'd1: begin trig_c = -stg_q[NS].y; trig_s = stg_q[NS].x; end
      2'd2: begin trig_c = -stg_q[NS].x; trig_s = -stg_q[NS].y; end
      default: begin trig_c = stg_q[NS].y; trig_s = -stg_q[NS].x; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else if (advance) begin
      mul_q <= stg_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      px_q <= PROD_W'($signed({1'b0, stg_q[NS].rad}) * trig_c);
      py_q <= PROD_W'($signed({1'b0, stg_q[NS].rad}) * trig_s);
    end
  end

  logic signed [PROD_W-1:0] rx, ry;
  logic signed [OFF_W-1:0] offx, offy;
  logic signed [SUM_W-1:0] sx, sy;
  localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] LO = -SUM_W'(64'sd1 <<< (COORD_BITS - 1));

  always_comb begin
    rx = (px_q + PROD_W'(1 << 29)) >>> 30;
    ry = (py_q + PROD_W'(1 << 29)) >>> 30;
    offx = mul_q.sq ? mul_q.off_x : rx[OFF_W-1:0];
    offy = mul_q.sq ? mul_q.off_y : ry[OFF_W-1:0];
    sx = SUM_W'(mul_q.cx) + SUM_W'(offx);
    sy = SUM_W'(mul_q.cy) + SUM_W'(offy);
    if (sx > HI) sx = HI;
    if (sx < LO) sx = LO;
    if (sy > HI) sy = HI;
    if (sy < LO) sy = LO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= mul_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ox_q <= sx[COORD_BITS-1:0];
      oy_q <= sy[COORD_BITS-1:0];
      oidx_q <= mul_q.idx;
      olast_q <= mul_q.last;
    end
  end

  assign vtx.valid = out_valid_q;
  assign vtx.point_x = ox_q;
  assign vtx.point_y = oy_q;
  assign vtx.vertex_index = oidx_q;
  assign vtx.last = olast_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");
  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (i_q < n_q)) else $error("vertex index beyond count");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < 8'(n_q))) else $error("divider remainder out of range");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!advance && state_q == ST_RUN) |=> $stable(stg_q[0].idx) && $stable(i_q))
    else $error("issue moved in stall");

endmodule

>>> sim/polygon_star_vertex_generator_tb.sv
// Testbench for the polygon and star vertex generator: directed and random requests, predicted vertices.
`timescale 1ns / 100ps

module polygon_star_vertex_generator_tb;
  import psvg_pkg::*;

  class vertex_scoreboard;
    typedef struct {
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic [5:0]         idx;
      logic               lst;
    } vertex_t;

    vertex_t pending_vertices[$];
    int      mismatch_count;

    function logic signed [23:0] clip24(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function void rotate(int unsigned ang, output longint c, output longint s);
      int unsigned phase;
      longint x, y, z, dx, dy;
      phase = ang << 16;
      z = phase & 32'h3FFF_FFFF;
      x = 652032874;
      y = 0;
      for (int k = 0; k < 24; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
        end
      end
      case (phase[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void push_vertex(longint x, longint y, int k, int n);
      vertex_t v;
      v.px = clip24(x);
      v.py = clip24(y);
      v.idx = k[5:0];
      v.lst = (k == n - 1);
      pending_vertices = {pending_vertices, v};
    endfunction

    function void note_request(mode_e mode, logic signed [23:0] cx24, logic signed [23:0] cy24,
                               logic [22:0] r1, logic [22:0] r2, logic [6:0] cnt);
      longint cx, cy, h, rad, c, s;
      int n, c_cl;
      int unsigned a;
      cx = cx24;
      cy = cy24;
      c_cl = cnt;
      if (mode == MODE_SQUARE) begin
        h = longint'(r1) >> 1;
        push_vertex(cx - h, cy - h, 0, 4);
        push_vertex(cx + h, cy - h, 1, 4);
        push_vertex(cx + h, cy + h, 2, 4);
        push_vertex(cx - h, cy + h, 3, 4);
        return;
      end
      if (mode == MODE_NONE) return;
      if (mode == MODE_CIRCLE) begin
        if (c_cl < 3) c_cl = 3;
        if (c_cl > 64) c_cl = 64;
        n = c_cl;
      end else begin
        if (c_cl < 2) c_cl = 2;
        if (c_cl > 32) c_cl = 32;
        n = 2 * c_cl;
      end
      for (int i = 0; i < n; i++) begin
        a = (i << 16) / n;
        rad = r1;
        if (mode == MODE_STAR) begin
          a = (a - 16384) & 16'hFFFF;
          if (i % 2 == 1) rad = r2;
        end
        rotate(a, c, s);
        push_vertex(cx + ((rad * c + (64'sd1 << 29)) >>> 30),
                    cy + ((rad * s + (64'sd1 << 29)) >>> 30), i, n);
      end
    endfunction

    task report_mismatch(string what);
      $display("vertex mismatch: %s", what);
      mismatch_count++;
    endtask

    task check_vertex(logic signed [23:0] px, logic signed [23:0] py,
                      logic [5:0] idx, logic lst);
      vertex_t e;
      if (pending_vertices.size() == 0) begin
        report_mismatch($sformatf("unexpected vertex idx %0d", idx));
        return;
      end
      e = pending_vertices.pop_front();
      if (px !== e.px || py !== e.py || idx !== e.idx || lst !== e.lst)
        report_mismatch($sformatf("got (%0d,%0d,%0d,%0b) exp (%0d,%0d,%0d,%0b)",
                                  px, py, idx, lst, e.px, e.py, e.idx, e.lst));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  vertex_scoreboard vertex_sb = new();

  psvg_req_if req ();
  psvg_vtx_if vtx ();

  polygon_star_vertex_generator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .vtx   (vtx.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.mode = '0;
    req.center_x = '0;
    req.center_y = '0;
    req.primary_length = '0;
    req.inner_radius = '0;
    req.count = '0;
    vtx.ready = 1'b0;
  end

  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 200) % 3 == 0) vtx.ready <= 1'b1;
    else vtx.ready <= ($urandom_range(0, 3) != 0);
    if (rst_ni && vtx.valid && vtx.ready)
      vertex_sb.check_vertex(vtx.point_x, vtx.point_y, vtx.vertex_index, vtx.last);
  end

  task automatic send_request(logic [1:0] m, logic [23:0] cx, logic [23:0] cy,
                              logic [22:0] r1, logic [22:0] r2, logic [6:0] cnt);
    req.valid <= 1'b1;
    req.mode <= m;
    req.center_x <= cx;
    req.center_y <= cy;
    req.primary_length <= r1;
    req.inner_radius <= r2;
    req.count <= cnt;
    do @(posedge clk_i); while (!req.ready);
    vertex_sb.note_request(mode_e'(m), cx, cy, r1, r2, cnt);
  endtask

  task automatic pause_sender();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'(24'h7FFFFF - $urandom_range(0, 2000));
      1: return 24'(24'h800000 + $urandom_range(0, 2000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [22:0] rand_len();
    case ($urandom_range(0, 3))
      0: return 23'(23'h7FFFFF - $urandom_range(0, 100));
      1: return 23'($urandom_range(0, 4000));
      default: return 23'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_request(MODE_CIRCLE, 0, 0, 23'd25600, 0, 7'd0);
    send_request(MODE_CIRCLE, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 0, 7'd64);
    send_request(MODE_CIRCLE, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 7'd127);
    send_request(MODE_CIRCLE, 24'd1000, 24'd2000, 23'd0, 0, 7'd3);
    send_request(MODE_CIRCLE, 0, 0, 23'd12345, 0, 7'd4);
    send_request(MODE_STAR, 0, 0, 23'd25600, 23'd10000, 7'd0);
    send_request(MODE_STAR, 0, 0, 23'h7FFFFF, 23'h7FFFFF, 7'd1);
    send_request(MODE_STAR, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 0, 7'd32);
    send_request(MODE_STAR, 24'h800000, 24'h800000, 0, 23'h7FFFFF, 7'd64);
    send_request(MODE_STAR, 0, 0, 23'd5000, 23'd2000, 7'd5);
    send_request(MODE_SQUARE, 0, 0, 23'd1, 0, 7'd0);
    send_request(MODE_SQUARE, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 7'd127);
    send_request(MODE_SQUARE, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 0, 7'd5);
    send_request(MODE_SQUARE, 24'd300, 24'hFFFF00, 23'd7, 0, 7'd64);
    send_request(MODE_NONE, 24'h123456, 24'h654321, 23'h7FFFFF, 23'h7FFFFF, 7'd127);
    send_request(MODE_NONE, 0, 0, 0, 0, 0);
    send_request(MODE_CIRCLE, 0, 0, 23'd2560, 0, 7'd63);
    pause_sender();
    for (int i = 0; i < 360; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, i++) begin
        logic [6:0] cnt;
        cnt = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
        if ($urandom_range(0, 19) == 0) cnt = 7'd64;
        send_request(2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                     rand_len(), rand_len(), cnt);
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    req.valid <= 1'b0;
    while (vertex_sb.pending_vertices.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (vertex_sb.mismatch_count == 0 && vertex_sb.pending_vertices.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
